// ===== rtl/piaw_pkg.sv =====
`default_nettype none

package piaw_pkg;

  // Port field width (fixed by the stream format)
  localparam int FIELD_W = 40;
  localparam int S_TDATA_W = 80;
  localparam int M_TDATA_W = 128;
  localparam int CFG_IDX_W = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PROP     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_INTEG    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_BACKCALC = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ERR_LIMIT     = 8'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_MAX     = 8'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_MIN     = 8'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_MAX     = 8'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_MIN     = 8'd7;

  // Saturation status codes
  localparam logic [1:0] SAT_NONE  = 2'd0;
  localparam logic [1:0] SAT_UPPER = 2'd1;
  localparam logic [1:0] SAT_LOWER = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_ECLAMP,
    ST_MSETUP,
    ST_MPP,
    ST_MRND,
    ST_MFIN,
    ST_SUM_U,
    ST_LIMIT,
    ST_EXCESS,
    ST_INT_ADD,
    ST_INT_SUB,
    ST_INT_CLAMP,
    ST_OUT
  } state_t;

  // Which gain/operand pair the shared multiplier works on
  typedef enum logic [1:0] {
    MUL_PROP,
    MUL_INTEG,
    MUL_BACK
  } mul_sel_t;

endpackage

`default_nettype wire

// ===== rtl/pi_controller_antiwindup.sv =====
// Control step: NPP = 2*ceil(SIGNAL_WIDTH/32) partial products per multiply, three multiplies per
// step; a new input is taken only after the previous step has reached the output register.
// Clear item: goes from idle straight to the output state. The rate is set by one shared 32x32
// multiplier, used for the proportional, integral and back-calculation products in turn.
// rst (synchronous) zeroes the integrator and all configuration registers and empties
// the output register.
`default_nettype none

module pi_controller_antiwindup #(
  parameter int SIGNAL_WIDTH   = 40,
  parameter int GAIN_FRAC_BITS = 24
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // input stream
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // [39:0] reference, [79:40] measurement
  input  wire logic [piaw_pkg::S_TDATA_W-1:0]   s_tdata,
  // [0] command (1 = clear integrator)
  input  wire logic                             s_tuser,
  // result stream
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // [39:0] drive_out, [79:40] clamped_error, [81:80] sat_state, [82] integ_held,
  // [122:83] integ_value, [127:123] zero
  output logic [piaw_pkg::M_TDATA_W-1:0]        m_tdata,
  // configuration write channel
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [piaw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [piaw_pkg::FIELD_W-1:0]     cfg_data
);

  localparam int S      = SIGNAL_WIDTH;
  localparam int F      = GAIN_FRAC_BITS;
  localparam int FW     = piaw_pkg::FIELD_W;
  localparam int CW     = (S > FW) ? S : FW;
  localparam int MC     = (S + 31) / 32;
  localparam int NPP    = 2 * MC;
  localparam int K_W    = $clog2(NPP + 1);
  localparam int MAG_W  = MC * 32;
  localparam int ACC_W  = MAG_W + 64;

  localparam logic [S-1:0] SMAX_S = {1'b0, {(S-1){1'b1}}};
  localparam logic [S-1:0] SMIN_S = {1'b1, {(S-1){1'b0}}};
  localparam logic signed [CW-1:0] SMAX_C = CW'(SMAX_S);
  localparam logic signed [CW-1:0] SMIN_C = ~SMAX_C;
  localparam logic [K_W-1:0] NPP_K = K_W'(NPP);
  localparam logic [ACC_W-1:0] RND_ACC = ACC_W'(1) << (F - 1);
  localparam logic [ACC_W-1:0] LIM_POS = ACC_W'(SMAX_S);
  localparam logic [ACC_W-1:0] LIM_NEG = ACC_W'(SMAX_S) + ACC_W'(1);

  // ---------------------------------------------------------------- helpers
  function automatic logic signed [S-1:0] sat_s(input logic signed [S:0] t);
    if (t[S] != t[S-1]) begin
      return t[S] ? SMIN_S : SMAX_S;
    end
    return t[S-1:0];
  endfunction

  function automatic logic signed [S-1:0] sat_add(input logic signed [S-1:0] a,
                                                  input logic signed [S-1:0] b);
    logic signed [S:0] t;
    t = {a[S-1], a} + {b[S-1], b};
    return sat_s(t);
  endfunction

  function automatic logic signed [S-1:0] sat_sub(input logic signed [S-1:0] a,
                                                  input logic signed [S-1:0] b);
    logic signed [S:0] t;
    t = {a[S-1], a} - {b[S-1], b};
    return sat_s(t);
  endfunction

  // 40-bit signed field into the internal range, saturating when narrower
  function automatic logic signed [S-1:0] to_sig(input logic [FW-1:0] v);
    logic signed [CW-1:0] w;
    w = CW'($signed(v));
    if (w > SMAX_C) begin
      return SMAX_S;
    end else if (w < SMIN_C) begin
      return SMIN_S;
    end
    return w[S-1:0];
  endfunction

  function automatic logic [FW-1:0] to_out(input logic signed [S-1:0] x);
    logic signed [CW-1:0] w;
    w = CW'(x);
    return w[FW-1:0];
  endfunction

  // ---------------------------------------------------------------- config
  logic [FW-1:0]       gain_prop;
  logic [FW-1:0]       gain_integ;
  logic [FW-1:0]       gain_backcalc;
  logic [FW-2:0]       err_limit;
  logic signed [S-1:0] drive_max;
  logic signed [S-1:0] drive_min;
  logic signed [S-1:0] integ_max;
  logic signed [S-1:0] integ_min;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_prop     <= '0;
      gain_integ    <= '0;
      gain_backcalc <= '0;
      err_limit     <= '0;
      drive_max     <= '0;
      drive_min     <= '0;
      integ_max     <= '0;
      integ_min     <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        piaw_pkg::CFG_GAIN_PROP:     gain_prop     <= cfg_data;
        piaw_pkg::CFG_GAIN_INTEG:    gain_integ    <= cfg_data;
        piaw_pkg::CFG_GAIN_BACKCALC: gain_backcalc <= cfg_data;
        piaw_pkg::CFG_ERR_LIMIT:     err_limit     <= cfg_data[FW-2:0];
        piaw_pkg::CFG_DRIVE_MAX:     drive_max     <= to_sig(cfg_data);
        piaw_pkg::CFG_DRIVE_MIN:     drive_min     <= to_sig(cfg_data);
        piaw_pkg::CFG_INTEG_MAX:     integ_max     <= to_sig(cfg_data);
        piaw_pkg::CFG_INTEG_MIN:     integ_min     <= to_sig(cfg_data);
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- state
  piaw_pkg::state_t   state, state_next;
  piaw_pkg::mul_sel_t mul_sel;

  logic signed [S-1:0] ref_r, meas_r, err_r, u_r, drive_r, exc_r, prod_r;
  logic signed [S-1:0] integ_acc;
  logic [1:0]          sat_r;
  logic                held_r;

  // multiplier sequencer
  logic [MAG_W-1:0]    mag_r;
  logic                neg_r;
  logic [K_W-1:0]      k;
  logic [63:0]         pp_r;
  logic [K_W-1:0]      pp_sh;
  logic [ACC_W-1:0]    acc_r;
  logic [S-1:0]        q_r;

  logic                out_load;

  // ---------------------------------------------------------------- FSM
  always_comb begin
    state_next = state;
    case (state)
      piaw_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = s_tuser ? piaw_pkg::ST_OUT : piaw_pkg::ST_ERR;
        end
      end
      piaw_pkg::ST_ERR:    state_next = piaw_pkg::ST_ECLAMP;
      piaw_pkg::ST_ECLAMP: state_next = piaw_pkg::ST_MSETUP;
      piaw_pkg::ST_MSETUP: state_next = piaw_pkg::ST_MPP;
      piaw_pkg::ST_MPP: begin
        if (k == NPP_K) begin
          state_next = piaw_pkg::ST_MRND;
        end
      end
      piaw_pkg::ST_MRND:   state_next = piaw_pkg::ST_MFIN;
      piaw_pkg::ST_MFIN: begin
        case (mul_sel)
          piaw_pkg::MUL_PROP:  state_next = piaw_pkg::ST_SUM_U;
          piaw_pkg::MUL_INTEG: state_next = piaw_pkg::ST_INT_ADD;
          default:             state_next = piaw_pkg::ST_INT_SUB;
        endcase
      end
      piaw_pkg::ST_SUM_U:     state_next = piaw_pkg::ST_LIMIT;
      piaw_pkg::ST_LIMIT:     state_next = piaw_pkg::ST_EXCESS;
      piaw_pkg::ST_EXCESS:    state_next = piaw_pkg::ST_MSETUP;
      piaw_pkg::ST_INT_ADD:   state_next = piaw_pkg::ST_MSETUP;
      piaw_pkg::ST_INT_SUB:   state_next = piaw_pkg::ST_INT_CLAMP;
      piaw_pkg::ST_INT_CLAMP: state_next = piaw_pkg::ST_OUT;
      piaw_pkg::ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          state_next = piaw_pkg::ST_IDLE;
        end
      end
      default: state_next = piaw_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == piaw_pkg::ST_IDLE);
    out_load = (state == piaw_pkg::ST_OUT) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= piaw_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------------------------------------------------------- datapath
  logic [FW-1:0]        gain_sel;
  logic signed [S-1:0]  mul_x;
  logic [S-1:0]         mag_abs;
  logic [63:0]          gain64;
  logic [MAG_W-1:0]     mag_sh;
  logic [31:0]          mag_chunk, gain_chunk;
  logic [63:0]          pp_c;
  logic [ACC_W-1:0]     rounded, q_full, lim_acc;
  logic signed [CW-1:0] lim_w;
  logic signed [S-1:0]  lim_s, neg_lim;
  logic                 err_pos, err_neg;

  always_comb begin
    case (mul_sel)
      piaw_pkg::MUL_PROP:  gain_sel = gain_prop;
      piaw_pkg::MUL_INTEG: gain_sel = gain_integ;
      default:             gain_sel = gain_backcalc;
    endcase
    mul_x   = (mul_sel == piaw_pkg::MUL_BACK) ? exc_r : err_r;
    mag_abs = mul_x[S-1] ? (~mul_x + 1'b1) : mul_x;

    gain64     = {{(64-FW){1'b0}}, gain_sel};
    gain_chunk = k[0] ? gain64[63:32] : gain64[31:0];
    mag_sh     = mag_r >> {k[K_W-1:1], 5'b0};
    mag_chunk  = mag_sh[31:0];
    pp_c       = mag_chunk * gain_chunk;

    // round half away from zero on the magnitude, then saturate
    rounded = acc_r + RND_ACC;
    q_full  = rounded >> F;
    lim_acc = neg_r ? LIM_NEG : LIM_POS;

    lim_w   = CW'({1'b0, err_limit});
    lim_s   = (lim_w > SMAX_C) ? SMAX_S : lim_w[S-1:0];
    neg_lim = ~lim_s + 1'b1;

    err_pos = !err_r[S-1] && (err_r != '0);
    err_neg = err_r[S-1];
  end

  always_ff @(posedge clk) begin
    case (state)
      piaw_pkg::ST_IDLE: begin
        ref_r  <= to_sig(s_tdata[FW-1:0]);
        meas_r <= to_sig(s_tdata[2*FW-1:FW]);
        if (s_tvalid && s_tuser) begin
          err_r   <= '0;
          drive_r <= '0;
          sat_r   <= piaw_pkg::SAT_NONE;
          held_r  <= 1'b0;
        end
      end
      piaw_pkg::ST_ERR: begin
        err_r <= sat_sub(ref_r, meas_r);
      end
      piaw_pkg::ST_ECLAMP: begin
        if (err_r > lim_s) begin
          err_r <= lim_s;
        end else if (err_r < neg_lim) begin
          err_r <= neg_lim;
        end
        mul_sel <= piaw_pkg::MUL_PROP;
      end
      piaw_pkg::ST_MSETUP: begin
        neg_r <= mul_x[S-1];
        mag_r <= MAG_W'(mag_abs);
        acc_r <= '0;
        k     <= '0;
      end
      piaw_pkg::ST_MPP: begin
        if (k != NPP_K) begin
          pp_r  <= pp_c;
          pp_sh <= {1'b0, k[K_W-1:1]} + {{(K_W-1){1'b0}}, k[0]};
          k     <= k + 1'b1;
        end
        // partial product from the previous cycle
        if (k != '0) begin
          acc_r <= acc_r + (ACC_W'(pp_r) << {pp_sh, 5'b0});
        end
      end
      piaw_pkg::ST_MRND: begin
        q_r <= (q_full > lim_acc) ? lim_acc[S-1:0] : q_full[S-1:0];
      end
      piaw_pkg::ST_MFIN: begin
        prod_r <= neg_r ? (~q_r + 1'b1) : q_r;
      end
      piaw_pkg::ST_SUM_U: begin
        u_r <= sat_add(integ_acc, prod_r);
      end
      piaw_pkg::ST_LIMIT: begin
        // upper test first, so with crossed limits any value above drive_max gives the upper one
        if (u_r > drive_max) begin
          drive_r <= drive_max;
          sat_r   <= piaw_pkg::SAT_UPPER;
        end else if (u_r < drive_min) begin
          drive_r <= drive_min;
          sat_r   <= piaw_pkg::SAT_LOWER;
        end else begin
          drive_r <= u_r;
          sat_r   <= piaw_pkg::SAT_NONE;
        end
      end
      piaw_pkg::ST_EXCESS: begin
        held_r  <= ((drive_r >= drive_max) && err_pos) ||
                   ((drive_r <= drive_min) && err_neg);
        exc_r   <= sat_sub(u_r, drive_r);
        mul_sel <= piaw_pkg::MUL_INTEG;
      end
      piaw_pkg::ST_INT_ADD: begin
        mul_sel <= piaw_pkg::MUL_BACK;
      end
      default: ;
    endcase
  end

  // integrator state
  always_ff @(posedge clk) begin
    if (rst) begin
      integ_acc <= '0;
    end else begin
      case (state)
        piaw_pkg::ST_IDLE: begin
          if (s_tvalid && s_tuser) begin
            integ_acc <= '0;
          end
        end
        piaw_pkg::ST_INT_ADD: begin
          if (!held_r) begin
            integ_acc <= sat_add(integ_acc, prod_r);
          end
        end
        piaw_pkg::ST_INT_SUB: begin
          integ_acc <= sat_sub(integ_acc, prod_r);
        end
        piaw_pkg::ST_INT_CLAMP: begin
          if (integ_acc > integ_max) begin
            integ_acc <= integ_max;
          end else if (integ_acc < integ_min) begin
            integ_acc <= integ_min;
          end
        end
        default: ;
      endcase
    end
  end

  // output register: a finished item waits here while the next one is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
      m_tdata  <= {5'b0, to_out(integ_acc), held_r, sat_r, to_out(err_r), to_out(drive_r)};
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

`default_nettype wire
